// ----- design/ist_pkg.sv -----
// ist_pkg: shared constants and codes for the index set table.
// Depends on nothing; used by the interfaces, the RAM users and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ist_pkg;

  localparam int CAPACITY    = 256;
  localparam int VALUE_WIDTH = 32;

  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OPCODE_W = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 8;

  localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_MEMBER = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

endpackage

`default_nettype wire

// ----- design/ist_in_if.sv -----
// ist_in_if: request channel of the index set table (opcode and value).
// Depends on ist_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ist_in_if;
  logic                         valid;
  logic                         ready;
  logic [ist_pkg::OPCODE_W-1:0] opcode;
  logic [ist_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

// ----- design/ist_out_if.sv -----
// ist_out_if: result channel of the index set table (status, position, count).
// Depends on ist_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ist_out_if;
  logic                         valid;
  logic                         ready;
  logic [ist_pkg::STATUS_W-1:0] status;
  logic [ist_pkg::POS_W-1:0]    position;
  logic [ist_pkg::CNT_W-1:0]    entry_count;

  modport source (output valid, output status, output position, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input position, input entry_count,
                  output ready);
endinterface

`default_nettype wire

// ----- design/ist_ram.sv -----
// ist_ram: generic simple dual-port RAM, one write and one registered read port.
// Standalone; holds the entry store of the index set table.
`timescale 1ns / 1ps
`default_nettype none

module ist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/index_set_table_unit.sv -----
// index_set_table_unit: fixed-capacity unordered set with swap-on-remove.
// Depends on ist_pkg, ist_in_if, ist_out_if and ist_ram.
//
//   channel | dir | fields                          | handshake
//   in_ch   | in  | opcode, value                   | valid / ready
//   out_ch  | out | status, position, entry_count   | valid / ready
//
// Append and unused opcodes go from accept straight to the finishing step.
// Member and remove scan from the top entry down through the one RAM read
// port, one entry per cycle pipelined; remove then reads the last entry and
// writes it into the freed slot, and the count drops by one.
// Reset clears the count; entries are never read above the count.
// in_ch is ready only in idle; a held result stalls the finishing step.
`timescale 1ns / 1ps
`default_nettype none

module index_set_table_unit (
  input wire logic  clk,
  input wire logic  rst_n,
  ist_in_if.sink    in_ch,
  ist_out_if.source out_ch
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_LAST_RD = 3'd2;
  localparam logic [2:0] S_LAST_WR = 3'd3;
  localparam logic [2:0] S_FINISH  = 3'd4;

  logic [2:0]                       state_r, state_nxt;
  logic [ist_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic [ist_pkg::OPCODE_W-1:0]     op_r, op_nxt;
  logic [ist_pkg::VALUE_WIDTH-1:0]  val_r, val_nxt;
  logic [ist_pkg::ADDR_W-1:0]       scan_addr_r, scan_addr_nxt;
  logic [ist_pkg::CNT_W-1:0]        scan_left_r, scan_left_nxt;
  logic                             cmp_vld_r, cmp_vld_nxt;
  logic [ist_pkg::ADDR_W-1:0]       cmp_addr_r, cmp_addr_nxt;
  logic [ist_pkg::STATUS_W-1:0]     res_status_r, res_status_nxt;
  logic [ist_pkg::ADDR_W-1:0]       res_slot_r, res_slot_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [ist_pkg::STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [ist_pkg::POS_W-1:0]        out_pos_r, out_pos_nxt;
  logic [ist_pkg::CNT_W-1:0]        out_count_r, out_count_nxt;

  logic                             ram_wr_en;
  logic [ist_pkg::ADDR_W-1:0]       ram_wr_addr;
  logic [ist_pkg::VALUE_WIDTH-1:0]  ram_wr_data;
  logic                             ram_rd_en;
  logic [ist_pkg::ADDR_W-1:0]       ram_rd_addr;
  logic [ist_pkg::VALUE_WIDTH-1:0]  ram_rd_data;

  logic [ist_pkg::CNT_W-1:0]        count_dec;
  logic                             out_free;
  logic                             hit;

  assign count_dec = count_r - ist_pkg::CNT_W'(1);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign hit       = cmp_vld_r && (ram_rd_data == val_r);

  ist_ram #(
    .WIDTH (ist_pkg::VALUE_WIDTH),
    .DEPTH (ist_pkg::CAPACITY)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    scan_addr_nxt  = scan_addr_r;
    scan_left_nxt  = scan_left_r;
    cmp_vld_nxt    = 1'b0;
    cmp_addr_nxt   = cmp_addr_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_count_nxt  = out_count_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = count_r[ist_pkg::ADDR_W-1:0];
    ram_wr_data    = val_r;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = scan_addr_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt         = in_ch.opcode;
          val_nxt        = in_ch.value[ist_pkg::VALUE_WIDTH-1:0];
          res_status_nxt = ist_pkg::ST_OK;
          res_slot_nxt   = '0;
          state_nxt      = S_FINISH;
          priority if (in_ch.opcode == ist_pkg::OP_APPEND) begin
            if (count_r == ist_pkg::CNT_W'(ist_pkg::CAPACITY)) begin
              res_status_nxt = ist_pkg::ST_FULL;
            end else begin
              ram_wr_en    = 1'b1;
              ram_wr_data  = in_ch.value[ist_pkg::VALUE_WIDTH-1:0];
              res_slot_nxt = count_r[ist_pkg::ADDR_W-1:0];
              count_nxt    = count_r + ist_pkg::CNT_W'(1);
            end
          end else if (in_ch.opcode == ist_pkg::OP_MEMBER ||
                       in_ch.opcode == ist_pkg::OP_REMOVE) begin
            if (count_r == '0) begin
              res_status_nxt = ist_pkg::ST_ABSENT;
            end else begin
              scan_addr_nxt = count_dec[ist_pkg::ADDR_W-1:0];
              scan_left_nxt = count_r;
              state_nxt     = S_SCAN;
            end
          end else begin
            // unused opcode: report ok with no change
            state_nxt = S_FINISH;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          res_slot_nxt = cmp_addr_r;
          state_nxt    = (op_r == ist_pkg::OP_REMOVE) ? S_LAST_RD : S_FINISH;
        end else if (cmp_vld_r && scan_left_r == '0) begin
          res_status_nxt = ist_pkg::ST_ABSENT;
          state_nxt      = S_FINISH;
        end else if (scan_left_r != '0) begin
          // issue the next lower entry while the previous one is compared
          ram_rd_en     = 1'b1;
          ram_rd_addr   = scan_addr_r;
          cmp_vld_nxt   = 1'b1;
          cmp_addr_nxt  = scan_addr_r;
          scan_addr_nxt = scan_addr_r - ist_pkg::ADDR_W'(1);
          scan_left_nxt = scan_left_r - ist_pkg::CNT_W'(1);
        end
      end

      S_LAST_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = count_dec[ist_pkg::ADDR_W-1:0];
        state_nxt   = S_LAST_WR;
      end

      S_LAST_WR: begin
        // move the last entry into the freed slot
        ram_wr_en   = 1'b1;
        ram_wr_addr = res_slot_r;
        ram_wr_data = ram_rd_data;
        count_nxt   = count_dec;
        state_nxt   = S_FINISH;
      end

      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pos_nxt    = ist_pkg::POS_W'(res_slot_r);
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    scan_addr_r  <= scan_addr_nxt;
    scan_left_r  <= scan_left_nxt;
    cmp_addr_r   <= cmp_addr_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.position    = out_pos_r;
  assign out_ch.entry_count = out_count_r;

endmodule

`default_nettype wire
